### rtl/line_sensor_dip_locator_defines.svh
// assertion macros for the dip locator
// no dependencies
`ifndef LINE_SENSOR_DIP_LOCATOR_DEFINES_SVH
`define LINE_SENSOR_DIP_LOCATOR_DEFINES_SVH
`define LSDL_ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lsdl check");
`define LSDL_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lsdl check");
`endif

### rtl/lsdl_pkg.sv
// types and constants for the dip locator
// no dependencies
package lsdl_pkg;
  localparam int MaxPixels = 2048;
  localparam int MaxFrames = 64;
  localparam logic [18:0] PosMax = 19'h7FFFF;

  localparam logic [2:0] CfgFrameCount = 3'd0;
  localparam logic [2:0] CfgLineLength = 3'd1;
  localparam logic [2:0] CfgWinStart   = 3'd2;
  localparam logic [2:0] CfgWinEnd     = 3'd3;
  localparam logic [2:0] CfgAlarmLow   = 3'd4;
  localparam logic [2:0] CfgAlarmHigh  = 3'd5;

  typedef enum logic [3:0] {
    ST_ACC, ST_DIV_RD, ST_DIV_WAIT, ST_DIV, ST_DIV_WR, ST_SCAN_RD, ST_SCAN_WAIT,
    ST_SCAN, ST_FIT_RD, ST_FIT_WAIT, ST_FIT_GET, ST_FIT_DIV, ST_OUT, ST_CLEAR
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

### rtl/lsdl_divider.sv
// shared restoring divider, one quotient bit per cycle
// depends on lsdl_pkg for the control struct
module lsdl_divider #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output lsdl_pkg::div_ctl_t status
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [W:0] trial;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {r_r, q_r[W-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend;
      r_nxt = '0;
      d_nxt = divisor;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[W-2:0], q_r[W-1]};
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign quotient = q_r;
  assign status.start = start;
  assign status.busy = busy_r;
endmodule

### rtl/line_sensor_dip_locator.sv
// line sensor dip locator: averages frames, finds the minimum, fits a dip
// depends on lsdl_pkg, lsdl_divider and line_sensor_dip_locator_defines.svh
//
// usage: pixels enter on in_valid/in_ready in readout order. while
// accumulating, each item takes a read, then a write of the sum store, and
// no new item is taken before that write. after frame_count frames of
// line_length pixels the block stops taking items and works through the
// store. every one of the max_pixels sums is divided by the frame count in
// the shared bit-serial divider. the window is then scanned from the value
// at its start. if the minimum is far enough inside the window and line,
// the five entries around it are read and, for a nonzero denominator, the
// fit offset is divided; else the coarse position is given.
// one result item is then held on out_valid, payload steady, until
// out_ready; a stalled receiver just holds the block in that state. after
// the result is taken the store is cleared one entry per cycle while
// further pixels wait.
// reset is synchronous: registers reload their reset values and a clearing
// pass over the whole store runs before the first pixel is accepted.
// configuration writes go on cfg_we/cfg_index/cfg_data between batches.
`include "line_sensor_dip_locator_defines.svh"
module line_sensor_dip_locator #(
  parameter int MAX_PIXELS = lsdl_pkg::MaxPixels,
  parameter int MAX_FRAMES = lsdl_pkg::MaxFrames
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_pixel_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [18:0] out_position_q8,
  output logic [10:0] out_coarse_index,
  output logic        out_fit_applied,
  output logic [1:0]  out_alarm_level,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [18:0] cfg_data
);
  localparam int AW = $clog2(MAX_PIXELS);
  localparam int IW = (AW + 2 > 13) ? AW + 2 : 13;
  localparam int SW = 16 + $clog2(MAX_FRAMES + 1);
  localparam int DW = 40;

  logic [6:0]  frame_count_r;
  logic [11:0] line_length_r;
  logic [10:0] window_start_r;
  logic [11:0] window_end_r;
  logic [18:0] alarm_low_r, alarm_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= 7'd10;
      line_length_r <= 12'd1500;
      window_start_r <= '0;
      window_end_r <= 12'd1500;
      alarm_low_r <= '0;
      alarm_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsdl_pkg::CfgFrameCount: frame_count_r <= cfg_data[6:0];
        lsdl_pkg::CfgLineLength: line_length_r <= cfg_data[11:0];
        lsdl_pkg::CfgWinStart:   window_start_r <= cfg_data[10:0];
        lsdl_pkg::CfgWinEnd:     window_end_r <= cfg_data[11:0];
        lsdl_pkg::CfgAlarmLow:   alarm_low_r <= cfg_data;
        lsdl_pkg::CfgAlarmHigh:  alarm_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame count and length
  logic [8:0] eff_f;
  logic [IW-1:0] eff_l, win_end, win_start;
  always_comb begin
    if (frame_count_r == '0) eff_f = 9'd1;
    else if (32'(frame_count_r) > MAX_FRAMES) eff_f = 9'(MAX_FRAMES);
    else eff_f = 9'(frame_count_r);
    if (line_length_r == '0) eff_l = IW'(1);
    else if (32'(line_length_r) > MAX_PIXELS) eff_l = IW'(MAX_PIXELS);
    else eff_l = IW'(line_length_r);
    win_end = (IW'(window_end_r) < eff_l) ? IW'(window_end_r) : eff_l;
    win_start = IW'(window_start_r);
  end

  // sum store, later overwritten by averages
  logic [SW-1:0] mem [MAX_PIXELS];
  logic [SW-1:0] rd_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [SW-1:0] wr_data;
  logic wr_en;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  lsdl_pkg::state_t st_r, st_nxt;
  logic [IW-1:0] pos_r, pos_nxt, idx_r, idx_nxt;
  logic [8:0] frames_r, frames_nxt;
  logic [15:0] px_r, px_nxt;
  logic [IW-1:0] best_r, best_nxt;
  logic [SW-1:0] bestv_r, bestv_nxt;
  logic signed [SW+2:0] y_r [5];
  logic signed [SW+2:0] y_nxt [5];
  logic [2:0] k_r, k_nxt;
  logic neg_r, neg_nxt;
  logic [18:0] opos_r, opos_nxt;
  logic [10:0] ocoarse_r, ocoarse_nxt;
  logic ofit_r, ofit_nxt;
  logic [1:0] oalarm_r, oalarm_nxt;

  logic div_start;
  logic [DW-1:0] div_a, div_b, div_q;
  lsdl_pkg::div_ctl_t div_st;
  lsdl_divider #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .quotient(div_q), .status(div_st)
  );

  logic signed [SW+4:0] num, den;
  logic signed [DW-1:0] ndx, dden;
  logic signed [DW-1:0] dx;
  logic signed [IW+9:0] pfit;
  logic [18:0] pos_fin;
  logic guard_ok;
  logic [IW-1:0] fit_idx;

  always_comb begin
    num = (SW+5)'(2 * (y_r[4] - y_r[0]) + (y_r[3] - y_r[1]));
    den = (SW+5)'(2 * (y_r[4] + y_r[0]) - (y_r[3] + y_r[1]) - 2 * y_r[2]);
    ndx = -DW'(7) * DW'(num) * DW'(256);
    dden = DW'(10) * DW'(den);
    guard_ok = !(best_r < IW'(2) || best_r + IW'(2) >= eff_l ||
                 {1'b0, best_r} < {1'b0, win_start} + (IW+1)'(2) ||
                 best_r + IW'(2) > win_end);
    fit_idx = best_r + IW'(k_r) - IW'(2);
    dx = neg_r ? -$signed(div_q) : $signed(div_q);
    if (dx > DW'(512)) dx = DW'(512);
    if (dx < -DW'(512)) dx = -DW'(512);
    pfit = $signed({2'b0, best_r, 8'b0}) + (IW+10)'(dx);
    if (pfit < 0) pos_fin = '0;
    else if (pfit > $signed((IW+10)'(lsdl_pkg::PosMax))) pos_fin = lsdl_pkg::PosMax;
    else pos_fin = pfit[18:0];
  end

  function automatic logic [1:0] alarm_of(logic [18:0] p, logic [18:0] lo,
                                          logic [18:0] hi);
    if (p > hi) return 2'd2;
    if (p > lo) return 2'd1;
    return 2'd0;
  endfunction

  logic [18:0] coarse_pos;
  assign coarse_pos = (32'(best_r) * 256 > 32'(lsdl_pkg::PosMax)) ? lsdl_pkg::PosMax
                      : 19'({best_r, 8'b0});

  always_comb begin
    st_nxt = st_r;
    pos_nxt = pos_r;
    idx_nxt = idx_r;
    frames_nxt = frames_r;
    px_nxt = px_r;
    best_nxt = best_r;
    bestv_nxt = bestv_r;
    y_nxt = y_r;
    k_nxt = k_r;
    neg_nxt = neg_r;
    opos_nxt = opos_r;
    ocoarse_nxt = ocoarse_r;
    ofit_nxt = ofit_r;
    oalarm_nxt = oalarm_r;
    rd_addr = pos_r[AW-1:0];
    wr_addr = pos_r[AW-1:0];
    wr_data = rd_r + SW'(px_r);
    wr_en = 1'b0;
    in_ready = 1'b0;
    div_start = 1'b0;
    div_a = DW'(rd_r);
    div_b = DW'(eff_f);
    unique case (st_r)
      lsdl_pkg::ST_ACC: begin
        // two phases: take item and read, then write
        if (k_r == 3'd0) begin
          in_ready = 1'b1;
          if (in_valid) begin
            px_nxt = in_pixel_value;
            if (pos_r >= eff_l) pos_nxt = '0;
            rd_addr = (pos_r >= eff_l) ? '0 : pos_r[AW-1:0];
            k_nxt = 3'd1;
          end
        end else begin
          k_nxt = 3'd0;
          wr_en = 1'b1;
          if (pos_r + IW'(1) < eff_l) pos_nxt = pos_r + IW'(1);
          else begin
            pos_nxt = '0;
            if (frames_r + 9'd1 >= eff_f) begin
              frames_nxt = '0;
              idx_nxt = '0;
              st_nxt = lsdl_pkg::ST_DIV_RD;
            end else frames_nxt = frames_r + 9'd1;
          end
        end
      end
      lsdl_pkg::ST_DIV_RD: begin
        rd_addr = idx_r[AW-1:0];
        st_nxt = lsdl_pkg::ST_DIV_WAIT;
      end
      lsdl_pkg::ST_DIV_WAIT: begin
        div_start = 1'b1;
        st_nxt = lsdl_pkg::ST_DIV;
      end
      lsdl_pkg::ST_DIV: begin
        if (!div_st.busy) st_nxt = lsdl_pkg::ST_DIV_WR;
      end
      lsdl_pkg::ST_DIV_WR: begin
        wr_en = 1'b1;
        wr_addr = idx_r[AW-1:0];
        wr_data = div_q[SW-1:0];
        if (idx_r == IW'(MAX_PIXELS - 1)) begin
          idx_nxt = win_start;
          best_nxt = win_start;
          k_nxt = 3'd0;
          st_nxt = lsdl_pkg::ST_SCAN_RD;
        end else begin
          idx_nxt = idx_r + IW'(1);
          st_nxt = lsdl_pkg::ST_DIV_RD;
        end
      end
      lsdl_pkg::ST_SCAN_RD: begin
        rd_addr = idx_r[AW-1:0];
        if (k_r == 3'd0) begin
          // initial best value: average at window start
          if (idx_r >= IW'(MAX_PIXELS)) begin
            bestv_nxt = '0;
            k_nxt = 3'd1;
          end else st_nxt = lsdl_pkg::ST_SCAN_WAIT;
        end else if (idx_r >= win_end) begin
          k_nxt = 3'd0;
          st_nxt = lsdl_pkg::ST_FIT_RD;
        end else st_nxt = lsdl_pkg::ST_SCAN_WAIT;
      end
      lsdl_pkg::ST_SCAN_WAIT: begin
        rd_addr = idx_r[AW-1:0];
        st_nxt = lsdl_pkg::ST_SCAN;
      end
      lsdl_pkg::ST_SCAN: begin
        if (k_r == 3'd0) begin
          bestv_nxt = rd_r;
          k_nxt = 3'd1;
        end else begin
          if (rd_r != '0 && rd_r <= bestv_r) begin
            bestv_nxt = rd_r;
            best_nxt = idx_r;
          end
          idx_nxt = idx_r + IW'(1);
        end
        st_nxt = lsdl_pkg::ST_SCAN_RD;
      end
      lsdl_pkg::ST_FIT_RD: begin
        rd_addr = fit_idx[AW-1:0];
        if (!guard_ok) begin
          opos_nxt = coarse_pos;
          ofit_nxt = 1'b0;
          st_nxt = lsdl_pkg::ST_OUT;
        end else st_nxt = lsdl_pkg::ST_FIT_WAIT;
      end
      lsdl_pkg::ST_FIT_WAIT: begin
        rd_addr = fit_idx[AW-1:0];
        st_nxt = lsdl_pkg::ST_FIT_GET;
      end
      lsdl_pkg::ST_FIT_GET: begin
        y_nxt[k_r] = (SW+3)'(rd_r);
        if (k_r == 3'd4) begin
          k_nxt = 3'd0;
          st_nxt = lsdl_pkg::ST_FIT_DIV;
        end else begin
          k_nxt = k_r + 3'd1;
          st_nxt = lsdl_pkg::ST_FIT_RD;
        end
      end
      lsdl_pkg::ST_FIT_DIV: begin
        if (k_r == 3'd0) begin
          if (den == '0) begin
            opos_nxt = coarse_pos;
            ofit_nxt = 1'b0;
            st_nxt = lsdl_pkg::ST_OUT;
          end else begin
            div_start = 1'b1;
            div_a = ndx[DW-1] ? DW'(-ndx) : DW'(ndx);
            div_b = dden[DW-1] ? DW'(-dden) : DW'(dden);
            neg_nxt = ndx[DW-1] ^ dden[DW-1];
            k_nxt = 3'd1;
          end
        end else if (!div_st.busy) begin
          opos_nxt = pos_fin;
          ofit_nxt = 1'b1;
          k_nxt = 3'd0;
          st_nxt = lsdl_pkg::ST_OUT;
        end
      end
      lsdl_pkg::ST_OUT: begin
        if (out_valid && out_ready) begin
          idx_nxt = '0;
          st_nxt = lsdl_pkg::ST_CLEAR;
        end
      end
      lsdl_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = idx_r[AW-1:0];
        wr_data = '0;
        if (idx_r == IW'(MAX_PIXELS - 1)) begin
          k_nxt = 3'd0;
          st_nxt = lsdl_pkg::ST_ACC;
        end else idx_nxt = idx_r + IW'(1);
      end
      default: st_nxt = lsdl_pkg::ST_CLEAR;
    endcase
    // result fields settle together with out_valid
    if (st_nxt == lsdl_pkg::ST_OUT && st_r != lsdl_pkg::ST_OUT) begin
      ocoarse_nxt = best_r[10:0];
      oalarm_nxt = alarm_of(opos_nxt, alarm_low_r, alarm_high_r);
    end
  end

  logic oval_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lsdl_pkg::ST_CLEAR;
      pos_r <= '0;
      idx_r <= '0;
      frames_r <= '0;
      k_r <= '0;
      oval_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pos_r <= pos_nxt;
      idx_r <= idx_nxt;
      frames_r <= frames_nxt;
      k_r <= k_nxt;
      oval_r <= (st_nxt == lsdl_pkg::ST_OUT) && !(out_valid && out_ready);
    end
    px_r <= px_nxt;
    best_r <= best_nxt;
    bestv_r <= bestv_nxt;
    y_r <= y_nxt;
    neg_r <= neg_nxt;
    opos_r <= opos_nxt;
    ocoarse_r <= ocoarse_nxt;
    ofit_r <= ofit_nxt;
    oalarm_r <= oalarm_nxt;
  end

  assign out_valid = oval_r;
  assign out_position_q8 = opos_r;
  assign out_coarse_index = ocoarse_r;
  assign out_fit_applied = ofit_r;
  assign out_alarm_level = oalarm_r;

  `LSDL_ASSERT_IMPL(a_ready_only_acc, clk, rst_n, in_ready, st_r == lsdl_pkg::ST_ACC)
  `LSDL_ASSERT_IMPL(a_no_in_while_out, clk, rst_n, out_valid, !in_ready)
  `LSDL_ASSERT_NEXT(a_out_to_clear, clk, rst_n, out_valid && out_ready,
                    st_r == lsdl_pkg::ST_CLEAR && !out_valid)
endmodule

### verif/tb.sv
// self-checking bench for line_sensor_dip_locator: frame averaging, minimum search,
// five-point fit and alarm level, checked against a behavioral dip predictor
// depends on lsdl_pkg and the line_sensor_dip_locator rtl
module tb;

  typedef struct {
    logic [18:0] position_q8;
    logic [10:0] coarse_index;
    logic        fit_applied;
    logic [1:0]  alarm_level;
  } dip_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_pixel_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [18:0] out_position_q8;
  logic [10:0] out_coarse_index;
  logic        out_fit_applied;
  logic [1:0]  out_alarm_level;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [18:0] cfg_data = '0;

  line_sensor_dip_locator DUT (.*);

  // predictor state
  int unsigned sums[lsdl_pkg::MaxPixels];
  int unsigned pix_pos, frames_done;
  int unsigned frame_count, line_length, win_start, win_end, alarm_low, alarm_high;

  dip_result_t expected_dips[$];
  int fails, n_sent, n_checked, n_settings;
  int send_idle, recv_idle;

  initial forever #4 clk = ~clk;

  initial begin
    #2000000000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic int unsigned eff_frames();
    if (frame_count == 0) return 1;
    if (frame_count > lsdl_pkg::MaxFrames) return lsdl_pkg::MaxFrames;
    return frame_count;
  endfunction

  function automatic int unsigned eff_length();
    if (line_length == 0) return 1;
    if (line_length > lsdl_pkg::MaxPixels) return lsdl_pkg::MaxPixels;
    return line_length;
  endfunction

  function automatic longint avg_at(int unsigned i);
    if (i >= lsdl_pkg::MaxPixels) return 0;
    return longint'(sums[i] / eff_frames());
  endfunction

  function automatic dip_result_t locate_dip();
    dip_result_t r;
    int unsigned len, e, best;
    longint bestv, v, y0, y1, y2, y3, y4, num, den, dx, p, pos;
    logic fit;
    len = eff_length();
    e = (win_end < len) ? win_end : len;
    best = win_start;
    bestv = avg_at(win_start);
    for (int unsigned i = win_start; i < e; i++) begin
      v = avg_at(i);
      if (v != 0 && v <= bestv) begin
        bestv = v;
        best = i;
      end
    end
    pos = longint'(best) * 256;
    fit = 1'b0;
    if (!(best < 2 || best + 2 >= len || best < win_start + 2 || best + 2 > e)) begin
      y0 = avg_at(best - 2); y1 = avg_at(best - 1); y2 = avg_at(best);
      y3 = avg_at(best + 1); y4 = avg_at(best + 2);
      num = 2 * (y4 - y0) + (y3 - y1);
      den = 2 * (y4 + y0) - (y3 + y1) - 2 * y2;
      if (den != 0) begin
        dx = (-7 * num * 256) / (10 * den);
        if (dx > 512) dx = 512;
        if (dx < -512) dx = -512;
        p = longint'(best) * 256 + dx;
        if (p < 0) p = 0;
        pos = p;
        fit = 1'b1;
      end
    end
    if (pos > lsdl_pkg::PosMax) pos = lsdl_pkg::PosMax;
    r.position_q8 = pos[18:0];
    r.coarse_index = best[10:0];
    r.fit_applied = fit;
    if (pos > alarm_high) r.alarm_level = 2'd2;
    else if (pos > alarm_low) r.alarm_level = 2'd1;
    else r.alarm_level = 2'd0;
    return r;
  endfunction

  function automatic void accumulate_pixel(logic [15:0] px);
    int unsigned len;
    len = eff_length();
    if (pix_pos >= len) pix_pos = 0;
    if (pix_pos < lsdl_pkg::MaxPixels) sums[pix_pos] += px;
    pix_pos++;
    if (pix_pos < len) return;
    pix_pos = 0;
    frames_done++;
    if (frames_done < eff_frames()) return;
    expected_dips.push_back(locate_dip());
    foreach (sums[i]) sums[i] = 0;
    frames_done = 0;
  endfunction

  function automatic void apply_setting(logic [2:0] idx, logic [18:0] d);
    case (idx)
      lsdl_pkg::CfgFrameCount: frame_count = d[6:0];
      lsdl_pkg::CfgLineLength: line_length = d[11:0];
      lsdl_pkg::CfgWinStart:   win_start = d[10:0];
      lsdl_pkg::CfgWinEnd:     win_end = d[11:0];
      lsdl_pkg::CfgAlarmLow:   alarm_low = d;
      lsdl_pkg::CfgAlarmHigh:  alarm_high = d;
      default: ;
    endcase
  endfunction

  task automatic send_pixel(input logic [15:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= v;
    do @(posedge clk); while (!in_ready);
    accumulate_pixel(v);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_dips.size() != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  // writes all six registers, plus an unknown index when asked
  task automatic write_settings(input logic [18:0] f, input logic [18:0] l,
                                input logic [18:0] ws, input logic [18:0] we,
                                input logic [18:0] lo, input logic [18:0] hi,
                                input bit junk);
    logic [18:0] vals[6];
    vals = '{f, l, ws, we, lo, hi};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      apply_setting(3'(i), vals[i]);
    end
    if (junk) begin
      cfg_index <= 3'(6 + $urandom_range(1));
      cfg_data <= 19'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  always @(posedge clk) begin
    dip_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_dips.size() == 0) begin
        $error("unexpected result item: position_q8 %0d", out_position_q8);
        fails++;
      end else begin
        e = expected_dips.pop_front();
        n_checked++;
        if (out_position_q8 !== e.position_q8) begin
          $error("position_q8 expected %0d actual %0d", e.position_q8, out_position_q8);
          fails++;
        end
        if (out_coarse_index !== e.coarse_index) begin
          $error("coarse_index expected %0d actual %0d", e.coarse_index, out_coarse_index);
          fails++;
        end
        if (out_fit_applied !== e.fit_applied) begin
          $error("fit_applied expected %0d actual %0d", e.fit_applied, out_fit_applied);
          fails++;
        end
        if (out_alarm_level !== e.alarm_level) begin
          $error("alarm_level expected %0d actual %0d", e.alarm_level, out_alarm_level);
          fails++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic test_directed();
    logic [15:0] dip[5];
    // defaults: a partial frame, then a lowered length; the position carries on
    send_pixel(16'd1234);
    send_pixel(16'd4321);
    write_settings(1, 5, 0, 5, 0, 19'h7FFFF, 1'b1);
    dip = '{16'd100, 16'd50, 16'd10, 16'd60, 16'd120};
    foreach (dip[i]) send_pixel(dip[i]);
    // five zero pixels: they finish the frame the dip pixels left open and begin another
    repeat (5) send_pixel(16'd0);
    // extreme pixel values with a high and low alarm pair
    write_settings(0, 5, 0, 4095, 100, 200, 1'b0);
    dip = '{16'hFFFF, 16'h0001, 16'h0000, 16'hFFFE, 16'h8000};
    foreach (dip[i]) send_pixel(dip[i]);
    // zero length reads as one pixel, empty window
    write_settings(127, 0, 2047, 0, 19'h7FFFF, 0, 1'b0);
    write_settings(1, 0, 2047, 0, 19'h7FFFF, 0, 1'b0);
    send_pixel(16'd7);
    send_pixel(16'd9);
    // reversed window, line longer than window end
    write_settings(1, 6, 4, 3, 0, 0, 1'b0);
    repeat (6) send_pixel(16'($urandom));
  endtask

  task automatic test_random();
    int unsigned len, frames, ws, we, c, base, depth, d, v, batches, pick;
    while (n_sent < 1800) begin
      if (n_sent > 1200) begin send_idle = 0; recv_idle = 0; end
      else if (n_sent > 600) begin send_idle = 77; recv_idle = 33; end
      pick = $urandom_range(19);
      len = (pick == 0) ? 64 : (pick < 3) ? 5 : $urandom_range(5, 12);
      frames = (pick == 1) ? 64 : (pick == 2) ? 127 : $urandom_range(0, 4);
      case ($urandom_range(3))
        0: begin ws = 0; we = 4095; end
        1: begin ws = $urandom_range(len + 2); we = $urandom_range(ws, len + 3); end
        2: begin ws = $urandom_range(len); we = $urandom_range(len); end
        default: begin ws = $urandom_range(2047); we = $urandom_range(4095); end
      endcase
      if ($urandom_range(3) == 0) write_settings(frames, len, ws, we, 0, 19'h7FFFF, 1'b1);
      else write_settings(frames, len, ws, we, $urandom_range(len * 256),
                          $urandom_range(len * 256), 1'($urandom_range(1)));
      batches = (pick < 3) ? 1 : $urandom_range(1, 3);
      len = eff_length();
      for (int b = 0; b < batches; b++) begin
        for (int f = 0; f < eff_frames(); f++) begin
          c = $urandom_range(len - 1);
          base = $urandom_range(65535);
          depth = $urandom_range(base / 4);
          for (int i = 0; i < len; i++) begin
            d = (i > c) ? i - c : c - i;
            v = base - ((d < 3) ? depth * (3 - d) / 3 : 0) + $urandom_range(15);
            if (v > 65535) v = 65535;
            case ($urandom_range(9))
              0: v = $urandom_range(65535);
              1: v = 0;
              default: ;
            endcase
            send_pixel(16'(v));
          end
        end
      end
      // broken batch: a stray run of up to one line of pixels
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, len)) send_pixel(16'($urandom));
    end
  endtask

  initial begin
    frame_count = 10; line_length = 1500; win_start = 0; win_end = 1500;
    alarm_low = 0; alarm_high = 0;
    pix_pos = 0; frames_done = 0;
    foreach (sums[i]) sums[i] = 0;
    send_idle = 33;
    recv_idle = 77;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    drain();
    $display("tb: %0d pixels sent, %0d dip results checked over %0d register settings",
             n_sent, n_checked, n_settings);
    if (fails == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
